// ===== rtl/i2cmw_pkg.sv =====
// Package for the I2C master write sequencer: operation, status and error codes,
// the input word and result structures, and fixed constants. No dependencies.
package i2cmw_pkg;

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_START  = 2'd1,
        OP_STATUS = 2'd2
    } op_t;

    typedef enum logic [4:0] {
        ST_START     = 5'd1,
        ST_RESTART   = 5'd2,
        ST_ADDR_ACK  = 5'd3,
        ST_ADDR_NACK = 5'd4,
        ST_DATA_ACK  = 5'd5,
        ST_DATA_NACK = 5'd6,
        ST_ARB_LOST  = 5'd7
    } status_t;

    typedef enum logic [1:0] {
        ERR_OK      = 2'd0,
        ERR_BUSY    = 2'd1,
        ERR_ADDRESS = 2'd2,
        ERR_RETRIES = 2'd3
    } err_t;

    localparam logic [7:0] MAX_ADDRESS = 8'd127;
    localparam int unsigned CMD_SHIFT = 1;
    localparam logic [7:0] COUNT_MAX = 8'hFF;

    typedef struct packed {
        op_t        op;
        logic [7:0] addr;
        logic [7:0] length;
        logic [7:0] limit;
        logic [7:0] position;
        logic [7:0] value;
        status_t    status;
    } item_t;

    typedef struct packed {
        err_t       error;
        logic       load;
        logic       use_store;
        logic [7:0] data;
        logic       release_bus;
        logic       start;
        logic       stop;
        logic       busy;
    } res_t;

endpackage

// ===== rtl/i2c_master_write_sequencer.sv =====
// Top level of the I2C master write sequencer: input register, result register
// and handshakes. Depends on i2cmw_pkg, i2cmw_seq and i2cmw_store.
//
// Each input word carries one operation: load a byte into the transmit store,
// start a write to a seven-bit address, or report one bus status code. Every
// accepted word gives exactly one result word on the output channel, in order.
// The result tells the bus controller which byte to place in its shift
// register, whether to release the bus, and whether to raise START or STOP,
// together with an error code and the busy flag after the word.
// A word is taken into the input register, decoded there against the transfer
// state and the store once the result register can advance, and the result
// lands in the result register. One word is taken every cycle while the
// receiver does not stall, set by the single decode step between the two
// registers and the one read port of the store.
// When the receiver stalls, the result register holds its word and the input
// register keeps at most one further word, after which in_ready falls.
// Reset empties both registers and returns the block to ready with all
// transfer state cleared; store contents are undefined until loaded.
module i2c_master_write_sequencer
    import i2cmw_pkg::*;
#(
    parameter int BUFFER_DEPTH = 256
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] operation,
    input  logic [7:0] slave_address,
    input  logic [7:0] transfer_length,
    input  logic [7:0] retry_limit,
    input  logic [7:0] load_position,
    input  logic [7:0] load_value,
    input  logic [4:0] bus_status,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] error_code,
    output logic       load_data_reg,
    output logic [7:0] data_value,
    output logic       release_bus,
    output logic       request_start,
    output logic       request_stop,
    output logic       busy_res
);

    localparam int PTR_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

    logic             in_vld_reg;
    item_t            item_reg;
    logic             out_vld_reg;
    res_t             res_reg;
    res_t             res_next;
    logic             res_adv;
    logic             fire;
    logic             wr_en;
    logic [PTR_W-1:0] rd_addr;
    logic [7:0]       store_data;

    assign res_adv  = !out_vld_reg || out_ready;
    assign in_ready = !in_vld_reg || res_adv;
    assign fire     = in_vld_reg && res_adv;
    assign wr_en    = fire && (item_reg.op == OP_LOAD) &&
                      ({1'b0, item_reg.position} < 9'(BUFFER_DEPTH));

    i2cmw_seq #(
        .BUFFER_DEPTH (BUFFER_DEPTH),
        .PTR_W        (PTR_W)
    ) u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (fire),
        .item    (item_reg),
        .res     (res_next),
        .rd_addr (rd_addr)
    );

    i2cmw_store #(
        .BUFFER_DEPTH (BUFFER_DEPTH),
        .PTR_W        (PTR_W)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (item_reg.position[PTR_W-1:0]),
        .wr_data (item_reg.value),
        .rd_en   (fire),
        .rd_addr (rd_addr),
        .rd_data (store_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_vld_reg <= in_valid;
            end
            if (res_adv)
            begin
                out_vld_reg <= in_vld_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= '{op:       op_t'(operation),
                          addr:     slave_address,
                          length:   transfer_length,
                          limit:    retry_limit,
                          position: load_position,
                          value:    load_value,
                          status:   status_t'(bus_status)};
        end
        if (fire)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid     = out_vld_reg;
    assign error_code    = res_reg.error;
    assign load_data_reg = res_reg.load;
    assign data_value    = res_reg.use_store ? store_data : res_reg.data;
    assign release_bus   = res_reg.release_bus;
    assign request_start = res_reg.start;
    assign request_stop  = res_reg.stop;
    assign busy_res      = res_reg.busy;

endmodule

// ===== rtl/i2cmw_store.sv =====
// Transmit byte store: one write port and one read port with registered read data.
// Depends on nothing but its parameter.
module i2cmw_store #(
    parameter int BUFFER_DEPTH = 256,
    parameter int PTR_W = 8
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [PTR_W-1:0] wr_addr,
    input  logic [7:0]       wr_data,
    input  logic             rd_en,
    input  logic [PTR_W-1:0] rd_addr,
    output logic [7:0]       rd_data
);

    logic [7:0] mem [BUFFER_DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/i2cmw_seq.sv =====
// Transfer state and the decode of one word into its result and next state.
// Depends on i2cmw_pkg.
module i2cmw_seq
    import i2cmw_pkg::*;
#(
    parameter int BUFFER_DEPTH = 256,
    parameter int PTR_W = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             fire,
    input  item_t            item,
    output res_t             res,
    output logic [PTR_W-1:0] rd_addr
);

    logic             trans_reg, trans_next;
    logic [7:0]       index_reg, index_next;
    logic [7:0]       length_reg, length_next;
    logic [7:0]       limit_reg, limit_next;
    logic [7:0]       count_reg, count_next;
    logic [7:0]       cmd_reg, cmd_next;
    logic [PTR_W-1:0] ptr_reg, ptr_next;
    logic [7:0]       index_inc;
    logic [7:0]       count_bump;

    assign index_inc  = index_reg + 8'd1;
    assign count_bump = (count_reg == COUNT_MAX) ? count_reg : count_reg + 8'd1;
    assign rd_addr    = ptr_next;

    always_comb
    begin
        trans_next  = trans_reg;
        index_next  = index_reg;
        length_next = length_reg;
        limit_next  = limit_reg;
        count_next  = count_reg;
        cmd_next    = cmd_reg;
        ptr_next    = ptr_reg;
        res         = '0;
        case (item.op)
            OP_START:
            begin
                if (item.addr > MAX_ADDRESS)
                begin
                    res.error = ERR_ADDRESS;
                end
                else if (trans_reg)
                begin
                    res.error = ERR_BUSY;
                end
                else
                begin
                    length_next = item.length;
                    index_next  = '0;
                    ptr_next    = '0;
                    limit_next  = item.limit;
                    cmd_next    = 8'(item.addr << CMD_SHIFT);
                    trans_next  = 1'b1;
                    res.start   = 1'b1;
                end
            end
            OP_STATUS:
            begin
                if (trans_reg && (index_reg != length_reg))
                begin
                    case (item.status)
                        ST_START, ST_RESTART:
                        begin
                            res.load        = 1'b1;
                            res.data        = cmd_reg;
                            res.release_bus = 1'b1;
                        end
                        ST_ADDR_ACK:
                        begin
                            res.load        = 1'b1;
                            res.use_store   = 1'b1;
                            res.release_bus = 1'b1;
                            count_next      = '0;
                        end
                        ST_ADDR_NACK:
                        begin
                            res.load        = 1'b1;
                            res.data        = cmd_reg;
                            res.release_bus = 1'b1;
                            count_next      = count_bump;
                        end
                        ST_DATA_ACK:
                        begin
                            index_next = index_inc;
                            ptr_next   = (ptr_reg == PTR_W'(BUFFER_DEPTH - 1)) ?
                                         '0 : ptr_reg + PTR_W'(1);
                            if (index_inc != length_reg)
                            begin
                                res.load      = 1'b1;
                                res.use_store = 1'b1;
                            end
                            else
                            begin
                                res.stop   = 1'b1;
                                trans_next = 1'b0;
                            end
                            res.release_bus = 1'b1;
                            count_next      = '0;
                        end
                        ST_DATA_NACK:
                        begin
                            res.load        = 1'b1;
                            res.use_store   = 1'b1;
                            res.release_bus = 1'b1;
                            count_next      = count_bump;
                        end
                        default:
                        begin
                            trans_next = 1'b0;
                            count_next = '0;
                        end
                    endcase
                    if ((limit_reg != '0) && (count_next > limit_reg))
                    begin
                        trans_next      = 1'b0;
                        res.stop        = 1'b1;
                        res.release_bus = 1'b1;
                        count_next      = '0;
                        res.error       = ERR_RETRIES;
                    end
                end
            end
            default:
            begin
            end
        endcase
        res.busy = trans_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trans_reg  <= 1'b0;
            index_reg  <= '0;
            length_reg <= '0;
            limit_reg  <= '0;
            count_reg  <= '0;
            cmd_reg    <= '0;
            ptr_reg    <= '0;
        end
        else if (fire)
        begin
            trans_reg  <= trans_next;
            index_reg  <= index_next;
            length_reg <= length_next;
            limit_reg  <= limit_next;
            count_reg  <= count_next;
            cmd_reg    <= cmd_next;
            ptr_reg    <= ptr_next;
        end
    end

endmodule

// ===== rtl/i2cmw_checker.sv =====
// Port-level checks on the result channel of the I2C master write sequencer,
// bound to the top level. Depends on i2cmw_pkg.
module i2cmw_checker
    import i2cmw_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [1:0] error_code,
    input logic       load_data_reg,
    input logic [7:0] data_value,
    input logic       release_bus,
    input logic       request_start,
    input logic       request_stop,
    input logic       busy_res
);

    // A stalled result word keeps its data byte, error code and busy flag on the port.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(data_value) &&
            $stable(error_code) && $stable(busy_res))
        else $error("result word changed while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && request_start |->
            error_code == ERR_OK && busy_res && !release_bus && !request_stop)
        else $error("start request without a clean accepted start");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && request_stop |-> release_bus && !busy_res)
        else $error("stop request while still busy or without release");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && error_code == ERR_RETRIES |-> request_stop && load_data_reg)
        else $error("retry abort without stop and resend");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !load_data_reg |-> data_value == 8'd0)
        else $error("data byte given without a load");

endmodule

bind i2c_master_write_sequencer i2cmw_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .error_code    (error_code),
    .load_data_reg (load_data_reg),
    .data_value    (data_value),
    .release_bus   (release_bus),
    .request_start (request_start),
    .request_stop  (request_stop),
    .busy_res      (busy_res)
);

// ===== tb/i2cmw_write_checker.sv =====
// Checker for the I2C master write sequencer: watches both word channels, predicts
// each result word from its own copy of the transfer state and compares field by field.
// Depends on i2cmw_pkg; reports its failure count and outstanding predictions to the top.
module i2cmw_write_checker
    import i2cmw_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic [1:0] operation,
    input  logic [7:0] slave_address,
    input  logic [7:0] transfer_length,
    input  logic [7:0] retry_limit,
    input  logic [7:0] load_position,
    input  logic [7:0] load_value,
    input  logic [4:0] bus_status,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic [1:0] error_code,
    input  logic       load_data_reg,
    input  logic [7:0] data_value,
    input  logic       release_bus,
    input  logic       request_start,
    input  logic       request_stop,
    input  logic       busy_res,
    output int         fails,
    output int         pending
);

    typedef struct packed {
        err_t       err;
        logic       load;
        logic [7:0] data;
        logic       rel;
        logic       sta;
        logic       sto;
        logic       busy;
    } outcome_t;

    outcome_t   outcome_q[$];
    logic [7:0] tx_bytes[256];
    logic       sending      = 1'b0;
    logic [7:0] byte_index   = '0;
    logic [7:0] byte_count   = '0;
    logic [7:0] nack_ceiling = '0;
    logic [7:0] nack_run     = '0;
    logic [7:0] addr_byte    = '0;

    initial
    begin
        fails = 0;
        pending = 0;
    end

    function automatic void bump_nacks();
        if (nack_run != COUNT_MAX)
            nack_run = nack_run + 8'd1;
    endfunction

    function automatic outcome_t predict_word(input item_t w);
        outcome_t r;
        r.err  = ERR_OK;
        r.load = 1'b0;
        r.data = '0;
        r.rel  = 1'b0;
        r.sta  = 1'b0;
        r.sto  = 1'b0;
        case (w.op)
            OP_LOAD:
                tx_bytes[w.position] = w.value;
            OP_START:
            begin
                if (w.addr > MAX_ADDRESS)
                    r.err = ERR_ADDRESS;
                else if (sending)
                    r.err = ERR_BUSY;
                else
                begin
                    byte_count   = w.length;
                    byte_index   = '0;
                    nack_ceiling = w.limit;
                    addr_byte    = 8'(w.addr << CMD_SHIFT);
                    sending      = 1'b1;
                    r.sta        = 1'b1;
                end
            end
            OP_STATUS:
            begin
                if (sending && byte_index != byte_count)
                begin
                    case (w.status)
                        ST_START, ST_RESTART:
                        begin
                            r.load = 1'b1;
                            r.data = addr_byte;
                            r.rel  = 1'b1;
                        end
                        ST_ADDR_ACK:
                        begin
                            r.load   = 1'b1;
                            r.data   = tx_bytes[byte_index];
                            r.rel    = 1'b1;
                            nack_run = '0;
                        end
                        ST_ADDR_NACK:
                        begin
                            r.load = 1'b1;
                            r.data = addr_byte;
                            r.rel  = 1'b1;
                            bump_nacks();
                        end
                        ST_DATA_ACK:
                        begin
                            byte_index = byte_index + 8'd1;
                            if (byte_index != byte_count)
                            begin
                                r.load = 1'b1;
                                r.data = tx_bytes[byte_index];
                            end
                            else
                            begin
                                r.sto   = 1'b1;
                                sending = 1'b0;
                            end
                            r.rel    = 1'b1;
                            nack_run = '0;
                        end
                        ST_DATA_NACK:
                        begin
                            r.load = 1'b1;
                            r.data = tx_bytes[byte_index];
                            r.rel  = 1'b1;
                            bump_nacks();
                        end
                        default:
                        begin
                            sending  = 1'b0;
                            nack_run = '0;
                        end
                    endcase
                    if (nack_ceiling != '0 && nack_run > nack_ceiling)
                    begin
                        sending  = 1'b0;
                        r.sto    = 1'b1;
                        r.rel    = 1'b1;
                        nack_run = '0;
                        r.err    = ERR_RETRIES;
                    end
                end
            end
            default:
            begin
            end
        endcase
        r.busy = sending;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fails++;
        end
    endtask

    always @(posedge clk)
    begin : watch
        item_t    word;
        outcome_t want;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                word = {operation, slave_address, transfer_length, retry_limit,
                        load_position, load_value, bus_status};
                outcome_q.push_back(predict_word(word));
            end
            if (out_valid && out_ready)
            begin
                if (outcome_q.size() == 0)
                begin
                    $error("Result word arrived with no prediction outstanding.");
                    fails++;
                end
                else
                begin
                    want = outcome_q.pop_front();
                    check_field("error_code", 8'(want.err), 8'(error_code));
                    check_field("load_data_reg", 8'(want.load), 8'(load_data_reg));
                    check_field("data_value", want.data, data_value);
                    check_field("release_bus", 8'(want.rel), 8'(release_bus));
                    check_field("request_start", 8'(want.sta), 8'(request_start));
                    check_field("request_stop", 8'(want.sto), 8'(request_stop));
                    check_field("busy_res", 8'(want.busy), 8'(busy_res));
                end
            end
            pending = outcome_q.size();
        end
    end

endmodule

// ===== tb/tb_i2c_master_write_sequencer.sv =====
// Testbench top for the I2C master write sequencer: clock, reset, command word stimulus
// with random gaps and receiver stalls, a stall watchdog and the final verdict.
// Depends on i2cmw_pkg, the sequencer RTL and i2cmw_write_checker.
module tb_i2c_master_write_sequencer;
    import i2cmw_pkg::*;

    localparam logic [1:0] OP_SPARE     = 2'd3;
    localparam logic [4:0] ST_CODE_LOW  = 5'd0;
    localparam logic [4:0] ST_CODE_HIGH = 5'd31;
    localparam int STALL_LIMIT = 1000;
    localparam int WORD_TARGET = 850;
    localparam int CALM_FROM   = 760;
    localparam int LONG_HOLD   = 60;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [1:0] operation;
    logic [7:0] slave_address;
    logic [7:0] transfer_length;
    logic [7:0] retry_limit;
    logic [7:0] load_position;
    logic [7:0] load_value;
    logic [4:0] bus_status;
    logic       out_valid;
    logic       out_ready;
    logic [1:0] error_code;
    logic       load_data_reg;
    logic [7:0] data_value;
    logic       release_bus;
    logic       request_start;
    logic       request_stop;
    logic       busy_res;

    int fails;
    int pending;
    int words_sent = 0;
    bit calm = 1'b0;
    bit quiet = 1'b0;

    i2c_master_write_sequencer i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .operation       (operation),
        .slave_address   (slave_address),
        .transfer_length (transfer_length),
        .retry_limit     (retry_limit),
        .load_position   (load_position),
        .load_value      (load_value),
        .bus_status      (bus_status),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .error_code      (error_code),
        .load_data_reg   (load_data_reg),
        .data_value      (data_value),
        .release_bus     (release_bus),
        .request_start   (request_start),
        .request_stop    (request_stop),
        .busy_res        (busy_res)
    );

    i2cmw_write_checker i_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .operation       (operation),
        .slave_address   (slave_address),
        .transfer_length (transfer_length),
        .retry_limit     (retry_limit),
        .load_position   (load_position),
        .load_value      (load_value),
        .bus_status      (bus_status),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .error_code      (error_code),
        .load_data_reg   (load_data_reg),
        .data_value      (data_value),
        .release_bus     (release_bus),
        .request_start   (request_start),
        .request_stop    (request_stop),
        .busy_res        (busy_res),
        .fails           (fails),
        .pending         (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic logic [7:0] rnd8();
        return 8'($urandom);
    endfunction

    task automatic send_word(input logic [1:0] op, input logic [7:0] addr, len, lim,
                             pos, val, input logic [4:0] st);
        if (!calm && !quiet && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid        <= 1'b1;
        operation       <= op;
        slave_address   <= addr;
        transfer_length <= len;
        retry_limit     <= lim;
        load_position   <= pos;
        load_value      <= val;
        bus_status      <= st;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        words_sent++;
    endtask

    task automatic load_byte(input logic [7:0] pos, input logic [7:0] val);
        send_word(OP_LOAD, rnd8(), rnd8(), rnd8(), pos, val, 5'($urandom));
    endtask

    task automatic start_write(input logic [7:0] addr, input logic [7:0] len,
                               input logic [7:0] lim);
        send_word(OP_START, addr, len, lim, rnd8(), rnd8(), 5'($urandom));
    endtask

    task automatic bus_event(input logic [4:0] st);
        send_word(OP_STATUS, rnd8(), rnd8(), rnd8(), rnd8(), rnd8(), st);
    endtask

    initial
    begin : drain
        int hold;
        int taken;
        int squeeze_at;
        hold = 0;
        taken = 0;
        squeeze_at = 120;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n)
            begin
                if (out_valid && out_ready)
                    taken++;
                if (taken >= squeeze_at)
                begin
                    hold = LONG_HOLD;
                    squeeze_at += 400;
                end
                if (hold > 0)
                begin
                    hold--;
                    out_ready <= 1'b0;
                end
                else if (!calm && !quiet && $urandom_range(0, 4) == 0)
                begin
                    hold = $urandom_range(0, 3);
                    out_ready <= 1'b0;
                end
                else
                    out_ready <= 1'b1;
            end
        end
    end

    initial
    begin : watchdog
        int still;
        still = 0;
        while (still < STALL_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
                still = 0;
            else
                still++;
        end
        $display("[i2c_master_write_sequencer] ERROR");
        $finish;
    end

    initial
    begin : stimulus
        logic [7:0] lim;
        int         nbytes;
        rst_n           <= 1'b0;
        in_valid        <= 1'b0;
        operation       <= OP_LOAD;
        slave_address   <= '0;
        transfer_length <= '0;
        retry_limit     <= '0;
        load_position   <= '0;
        load_value      <= '0;
        bus_status      <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        load_byte(8'd0, 8'hFF);
        load_byte(8'd1, 8'h00);
        load_byte(8'd2, 8'hA5);
        load_byte(8'd3, 8'h5A);
        load_byte(8'd255, 8'h3C);
        bus_event(ST_START);
        start_write(8'd128, 8'd3, 8'd2);
        start_write(8'd255, 8'd3, 8'd2);
        start_write(8'd127, 8'd3, 8'd2);
        start_write(8'd0, 8'd1, 8'd0);
        bus_event(ST_START);
        bus_event(ST_ADDR_NACK);
        bus_event(ST_RESTART);
        bus_event(ST_ADDR_ACK);
        bus_event(ST_DATA_NACK);
        bus_event(ST_DATA_ACK);
        bus_event(ST_DATA_ACK);
        bus_event(ST_DATA_ACK);
        send_word(OP_SPARE, rnd8(), rnd8(), rnd8(), rnd8(), rnd8(), 5'($urandom));
        start_write(8'd0, 8'd255, 8'd1);
        bus_event(ST_START);
        bus_event(ST_ADDR_NACK);
        bus_event(ST_ADDR_NACK);
        start_write(8'h55, 8'd1, 8'd255);
        bus_event(ST_START);
        bus_event(ST_ARB_LOST);
        start_write(8'd9, 8'd2, 8'd0);
        bus_event(ST_CODE_LOW);
        start_write(8'd10, 8'd2, 8'd0);
        bus_event(ST_CODE_HIGH);

        // Every store entry is written before any transfer can read it.
        for (int p = 0; p < 256; p++)
            load_byte(8'(p), rnd8());

        // A long run of address NACKs with no limit drives the counter to saturation.
        start_write(8'($urandom_range(0, 127)), 8'd2, 8'd0);
        bus_event(ST_START);
        repeat (258) bus_event(ST_ADDR_NACK);
        bus_event(ST_ADDR_ACK);
        bus_event(ST_DATA_ACK);
        bus_event(ST_DATA_ACK);

        while (words_sent < WORD_TARGET)
        begin
            quiet = ($urandom_range(0, 4) == 0);
            calm = (words_sent >= CALM_FROM);
            repeat ($urandom_range(0, 2)) load_byte(rnd8(), rnd8());
            if ($urandom_range(0, 5) == 0)
                send_word(2'($urandom), rnd8(), 8'($urandom_range(1, 255)), rnd8(),
                          rnd8(), rnd8(), 5'($urandom));
            if ($urandom_range(0, 9) == 0)
                start_write(8'($urandom_range(128, 255)), rnd8(), rnd8());
            nbytes = ($urandom_range(0, 39) == 0) ? $urandom_range(32, 255)
                                                  : $urandom_range(1, 6);
            case ($urandom_range(0, 3))
                0: lim = 8'd0;
                1: lim = 8'($urandom_range(1, 3));
                2: lim = rnd8();
                default: lim = 8'd255;
            endcase
            start_write(8'($urandom_range(0, 127)), 8'(nbytes), lim);
            bus_event($urandom_range(0, 1) ? ST_START : ST_RESTART);
            repeat ($urandom_range(0, 3)) bus_event(ST_ADDR_NACK);
            bus_event(ST_ADDR_ACK);
            for (int b = 0; b < nbytes; b++)
            begin
                if ($urandom_range(0, 24) == 0)
                begin
                    bus_event($urandom_range(0, 1) ? ST_ARB_LOST : 5'($urandom));
                    break;
                end
                if ($urandom_range(0, 29) == 0)
                    start_write(8'($urandom_range(0, 127)), 8'($urandom_range(1, 255)),
                                rnd8());
                if ($urandom_range(0, 3) == 0)
                    repeat ($urandom_range(1, 2)) bus_event(ST_DATA_NACK);
                bus_event(ST_DATA_ACK);
            end
        end

        // A zero-length write leaves the sequencer busy for the rest of the run.
        calm = 1'b1;
        bus_event(ST_ARB_LOST);
        start_write(8'h21, 8'd0, 8'd0);
        bus_event(ST_START);
        bus_event(ST_DATA_ACK);
        start_write(8'h03, 8'd5, 8'd0);
        in_valid <= 1'b0;

        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (fails == 0)
            $display("[i2c_master_write_sequencer] OK");
        else
            $display("[i2c_master_write_sequencer] ERROR");
        $finish;
    end

endmodule
